// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define ONV_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check, also during reset
`define ONV_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/onv_pkg.sv
package onv_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_OCTAVES = 8;

  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 20;
  localparam int DIV_CNT_W = 6;

  localparam int OCT_W = $clog2(MAX_OCTAVES);

  localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd1;
  localparam logic [1:0] REG_INVERSE_BIAS = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_WRITE, OP_START, OP_CAPMOD, OP_PDIV, OP_FDIV,
    OP_RD0, OP_RD1, OP_RD2, OP_RD3, OP_RD4,
    OP_MT, OP_LT, OP_MB, OP_LB, OP_MY, OP_LY,
    OP_MA, OP_ACC, OP_MW, OP_NW, OP_FIN, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [OCT_W-1:0] oct;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/core/onv_div.sv
module onv_div
  import onv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  input  logic [DIV_CNT_W-1:0] steps,
  output logic                 busy,
  output logic [DIV_NUM_W-1:0] quo,
  output logic [DIV_DEN_W-1:0] rem
);

  logic [DIV_NUM_W-1:0] num_sh;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  assign trial = {rem, num_sh[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_q  <= den;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[DIV_NUM_W-2:0], 1'b0};
      rem    <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
      quo    <= {quo[DIV_NUM_W-2:0], ge};
    end
  end

endmodule

// File: rtl/core/onv_datapath.sv
module onv_datapath
  import onv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [7:0]  coord_x,
  input  logic [7:0]  coord_y,
  input  logic [15:0] seed_value,
  input  logic [8:0]  w_eff,
  input  logic [15:0] ib,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] noise_value,
  output logic [7:0]  out_x,
  output logic [7:0]  out_y
);

  logic [15:0] mem [0:65535];
  logic [15:0] rdata;
  logic [15:0] raddr;

  logic [7:0]  qx, qy, xm, ym, x1, x2, y1, y2;
  logic [15:0] bx, by, s00, s01, s10, s11, top, bot, val;
  logic [16:0] weight;
  logic [35:0] sum;
  logic [19:0] tw;
  logic signed [35:0] prod;

  logic signed [17:0] mul_a, mul_b;
  logic [8:0]  pitch_raw, pitch;
  logic [9:0]  x2_sum, y2_sum;
  logic [7:0]  x1_new, y1_new;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] num_x, num_y;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_CNT_W-1:0] steps;
  logic                 busy_x, busy_y;
  logic [DIV_NUM_W-1:0] quo_x, quo_y;
  logic [DIV_DEN_W-1:0] rem_x, rem_y;
  logic [35:0]          fin_num;

  function automatic logic [15:0] lerp_fin(input logic [15:0] a, input logic signed [35:0] p);
    logic signed [35:0] t;
    logic signed [17:0] s;
    t = p + 36'sd32768;
    t = t >>> 16;
    s = $signed({2'b00, a}) + t[17:0];
    return s[15:0];
  endfunction

  assign pitch_raw = w_eff >> cmd.oct;
  assign pitch     = (pitch_raw == 9'd0) ? 9'd1 : pitch_raw;
  assign x1_new    = xm - rem_x[7:0];
  assign y1_new    = ym - rem_y[7:0];
  assign x2_sum    = {2'b00, x1_new} + {1'b0, pitch};
  assign y2_sum    = {2'b00, y1_new} + {1'b0, pitch};
  assign fin_num   = sum + {17'd0, tw[19:1]};

  assign sts.div_busy = busy_x || busy_y;
  assign sts.out_free = !out_valid || !out_stall;

  always_comb begin
    div_start = 1'b0;
    num_x     = '0;
    num_y     = '0;
    den       = '0;
    steps     = '0;
    unique case (cmd.op)
      OP_START: begin
        div_start = 1'b1;
        num_x     = {coord_x, 32'd0};
        num_y     = {coord_y, 32'd0};
        den       = {11'd0, w_eff};
        steps     = DIV_CNT_W'(8);
      end
      OP_PDIV: begin
        div_start = 1'b1;
        num_x     = {xm, 32'd0};
        num_y     = {ym, 32'd0};
        den       = {11'd0, pitch};
        steps     = DIV_CNT_W'(8);
      end
      OP_FDIV: begin
        div_start = 1'b1;
        num_x     = {rem_x[7:0], 32'd0};
        num_y     = {rem_y[7:0], 32'd0};
        den       = {11'd0, pitch};
        steps     = DIV_CNT_W'(24);
      end
      OP_FIN: begin
        div_start = 1'b1;
        num_x     = {fin_num, 4'd0};
        den       = tw;
        steps     = DIV_CNT_W'(36);
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      OP_RD1:  raddr = {y1, x2};
      OP_RD2:  raddr = {y2, x1};
      OP_RD3:  raddr = {y2, x2};
      default: raddr = {y1, x1};
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      OP_MT: begin
        mul_a = $signed({2'b00, bx});
        mul_b = $signed({2'b00, s01}) - $signed({2'b00, s00});
      end
      OP_MB: begin
        mul_a = $signed({2'b00, bx});
        mul_b = $signed({2'b00, s11}) - $signed({2'b00, s10});
      end
      OP_MY: begin
        mul_a = $signed({2'b00, by});
        mul_b = $signed({2'b00, bot}) - $signed({2'b00, top});
      end
      OP_MA: begin
        mul_a = $signed({2'b00, val});
        mul_b = $signed({1'b0, weight});
      end
      default: begin
        mul_a = $signed({1'b0, weight});
        mul_b = $signed({2'b00, ib});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      mem[{coord_y, coord_x}] <= seed_value;
    end
    rdata <= mem[raddr];
  end

  onv_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(num_x), .den(den), .steps(steps),
    .busy(busy_x), .quo(quo_x), .rem(rem_x)
  );

  onv_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(num_y), .den(den), .steps(steps),
    .busy(busy_y), .quo(quo_y), .rem(rem_y)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        qx     <= coord_x;
        qy     <= coord_y;
        sum    <= '0;
        tw     <= '0;
        weight <= 17'h10000;
      end
      OP_CAPMOD: begin
        xm <= rem_x[7:0];
        ym <= rem_y[7:0];
      end
      OP_FDIV: begin
        x1 <= x1_new;
        y1 <= y1_new;
        x2 <= (x2_sum >= {1'b0, w_eff}) ? 8'(x2_sum - {1'b0, w_eff}) : x2_sum[7:0];
        y2 <= (y2_sum >= {1'b0, w_eff}) ? 8'(y2_sum - {1'b0, w_eff}) : y2_sum[7:0];
      end
      OP_RD0: begin
        bx <= quo_x[15:0];
        by <= quo_y[15:0];
      end
      OP_RD1: s00 <= rdata;
      OP_RD2: s01 <= rdata;
      OP_RD3: s10 <= rdata;
      OP_RD4: s11 <= rdata;
      OP_MT, OP_MB, OP_MY, OP_MA, OP_MW: prod <= mul_a * mul_b;
      OP_LT: top <= lerp_fin(s00, prod);
      OP_LB: bot <= lerp_fin(s10, prod);
      OP_LY: val <= lerp_fin(top, prod);
      OP_ACC: begin
        sum <= sum + prod;
        tw  <= tw + {3'd0, weight};
      end
      OP_NW: weight <= prod[32:16];
      OP_OUT: begin
        noise_value <= quo_x[15:0];
        out_x       <= qx;
        out_y       <= qy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/onv_ctrl.sv
`include "assert_macros.svh"

module onv_ctrl
  import onv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       req_type,
  output logic       in_stall,
  input  logic [3:0] nq,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [24:0] {
    S_IDLE   = 25'h0000001,
    S_MODW   = 25'h0000002,
    S_CAPMOD = 25'h0000004,
    S_PDIV   = 25'h0000008,
    S_PDIVW  = 25'h0000010,
    S_FDIV   = 25'h0000020,
    S_FDIVW  = 25'h0000040,
    S_RD0    = 25'h0000080,
    S_RD1    = 25'h0000100,
    S_RD2    = 25'h0000200,
    S_RD3    = 25'h0000400,
    S_RD4    = 25'h0000800,
    S_MT     = 25'h0001000,
    S_LT     = 25'h0002000,
    S_MB     = 25'h0004000,
    S_LB     = 25'h0008000,
    S_MY     = 25'h0010000,
    S_LY     = 25'h0020000,
    S_MA     = 25'h0040000,
    S_ACC    = 25'h0080000,
    S_MW     = 25'h0100000,
    S_NW     = 25'h0200000,
    S_FIN    = 25'h0400000,
    S_FINW   = 25'h0800000,
    S_OUT    = 25'h1000000
  } state_t;

  state_t           state, state_next;
  logic [OCT_W-1:0] oct, oct_next;
  logic             last_oct;

  assign in_stall = (state != S_IDLE);
  assign last_oct = ({1'b0, oct} + 4'd1) >= nq;

  always_comb begin
    state_next = state;
    oct_next   = oct;
    cmd.op     = OP_NONE;
    cmd.oct    = oct;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type) begin
            cmd.op     = OP_START;
            state_next = S_MODW;
          end else begin
            cmd.op = OP_WRITE;
          end
        end
      end
      S_MODW:   if (!sts.div_busy) state_next = S_CAPMOD;
      S_CAPMOD: begin
        cmd.op     = OP_CAPMOD;
        oct_next   = '0;
        state_next = S_PDIV;
      end
      S_PDIV: begin
        cmd.op     = OP_PDIV;
        state_next = S_PDIVW;
      end
      S_PDIVW:  if (!sts.div_busy) state_next = S_FDIV;
      S_FDIV: begin
        cmd.op     = OP_FDIV;
        state_next = S_FDIVW;
      end
      S_FDIVW:  if (!sts.div_busy) state_next = S_RD0;
      S_RD0: begin cmd.op = OP_RD0; state_next = S_RD1; end
      S_RD1: begin cmd.op = OP_RD1; state_next = S_RD2; end
      S_RD2: begin cmd.op = OP_RD2; state_next = S_RD3; end
      S_RD3: begin cmd.op = OP_RD3; state_next = S_RD4; end
      S_RD4: begin cmd.op = OP_RD4; state_next = S_MT;  end
      S_MT:  begin cmd.op = OP_MT;  state_next = S_LT;  end
      S_LT:  begin cmd.op = OP_LT;  state_next = S_MB;  end
      S_MB:  begin cmd.op = OP_MB;  state_next = S_LB;  end
      S_LB:  begin cmd.op = OP_LB;  state_next = S_MY;  end
      S_MY:  begin cmd.op = OP_MY;  state_next = S_LY;  end
      S_LY:  begin cmd.op = OP_LY;  state_next = S_MA;  end
      S_MA:  begin cmd.op = OP_MA;  state_next = S_ACC; end
      S_ACC: begin cmd.op = OP_ACC; state_next = S_MW;  end
      S_MW:  begin cmd.op = OP_MW;  state_next = S_NW;  end
      S_NW: begin
        cmd.op = OP_NW;
        if (last_oct) begin
          state_next = S_FIN;
        end else begin
          oct_next   = oct + 1'b1;
          state_next = S_PDIV;
        end
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = S_FINW;
      end
      S_FINW:   if (!sts.div_busy) state_next = S_OUT;
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      oct   <= '0;
    end else begin
      state <= state_next;
      oct   <= oct_next;
    end
  end

  `ONV_CHECK(a_div_idle_on_start, (cmd.op == OP_PDIV || cmd.op == OP_FDIV || cmd.op == OP_FIN) |-> !sts.div_busy, "divider started while busy")
  `ONV_CHECK(a_out_slot_free, (cmd.op == OP_OUT) |-> sts.out_free, "result written over a waiting one")
  `ONV_CHECK(a_oct_in_range, (state == S_NW) |-> ({1'b0, oct} < nq), "octave index past octave count")

endmodule

// File: rtl/core/octave_value_noise_2d.sv
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  req_type, coord_x, coord_y, seed_value
// out      from block out_valid / out_stall noise_value, out_x, out_y
// cfg      to block   APB psel/penable     paddr, pwdata, prdata
//
// A seed write is stored in the cycle it is taken. A query holds the input while
// the one-bit-per-cycle restoring divider runs (modulo, pitch quotient, blend
// fraction, final normalization) and the four seed reads are made.
// Synchronous reset; the seed store is not cleared and holds old data.
// A finished result waits in the output register while out_stall is high;
// the next item is taken only once the block is idle.
module octave_value_noise_2d
  import onv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  coord_x,
  input  logic [7:0]  coord_y,
  input  logic [15:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] noise_value,
  output logic [7:0]  out_x,
  output logic [7:0]  out_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]  grid_width;
  logic [3:0]  octave_count;
  logic [15:0] inverse_bias;
  logic [8:0]  w_eff;
  logic [3:0]  nq;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= 9'd256;
      octave_count <= 4'd5;
      inverse_bias <= 16'd36409;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_GRID_WIDTH:   grid_width   <= pwdata[8:0];
        REG_OCTAVE_COUNT: octave_count <= pwdata[3:0];
        REG_INVERSE_BIAS: inverse_bias <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GRID_WIDTH:   prdata = {23'd0, grid_width};
      REG_OCTAVE_COUNT: prdata = {28'd0, octave_count};
      REG_INVERSE_BIAS: prdata = {16'd0, inverse_bias};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    priority if (grid_width < 9'd2) w_eff = 9'd2;
    else if (grid_width > 9'(MAX_WIDTH)) w_eff = 9'(MAX_WIDTH);
    else w_eff = grid_width;
  end

  always_comb begin
    priority if (octave_count < 4'd1) nq = 4'd1;
    else if (octave_count > 4'(MAX_OCTAVES)) nq = 4'(MAX_OCTAVES);
    else nq = octave_count;
  end

  onv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .req_type(req_type),
    .in_stall(in_stall), .nq(nq), .sts(sts), .cmd(cmd)
  );

  onv_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .coord_x(coord_x), .coord_y(coord_y), .seed_value(seed_value),
    .w_eff(w_eff), .ib(inverse_bias),
    .out_valid(out_valid), .out_stall(out_stall),
    .noise_value(noise_value), .out_x(out_x), .out_y(out_y)
  );

endmodule
